/* rtl/pgb_pkg.sv */
// Shared types and constants of the particle grid binning block.
package pgb_pkg;

  // Field widths fixed by the interface
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned PIDX_W   = 12;
  localparam int unsigned SEL_W    = 10;
  localparam int unsigned CIDX_W   = 10;
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned INV_W    = 16;
  localparam int unsigned COLS_W   = 11;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Fixed-point arithmetic: Q5.12 difference times Q8.8 reciprocal gives Q14.20
  localparam int unsigned FRAC_BITS = 20;
  localparam int unsigned DIFF_W    = POS_W + 1;
  localparam int unsigned PROD_W    = DIFF_W + INV_W + 1;
  localparam int unsigned COORD_W   = DIFF_W + INV_W - FRAC_BITS;
  localparam int unsigned ROWP_W    = COORD_W + COLS_W + 1;
  localparam int unsigned SUM_W     = ROWP_W + 1;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_BIN   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_INV_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_INV_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS  = 3'd4;

  // Register reset values
  localparam logic [INV_W-1:0]  INV_STEP_RST  = 16'd256;
  localparam logic [COLS_W-1:0] GRID_COLS_RST = 11'd32;

  typedef struct packed {
    logic signed [POS_W-1:0] x_origin;
    logic signed [POS_W-1:0] y_origin;
    logic [INV_W-1:0]        x_inv_step;
    logic [INV_W-1:0]        y_inv_step;
    logic [COLS_W-1:0]       grid_columns;
  } cfg_t;

  // Control strobes towards the cell store
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_first_en;
  } mem_ctl_t;

endpackage

/* rtl/pgb_cell_calc.sv */
// Cell address pipeline: offset, scale, row multiply, combine and range check.
module pgb_cell_calc import pgb_pkg::*; #(
  parameter int unsigned CELLS = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [POS_W-1:0] pos_x_i,
  input  logic signed [POS_W-1:0] pos_y_i,
  input  cfg_t                    cfg_i,
  output logic                    valid_o,
  output logic [AW-1:0]           cell_o,
  output logic                    oor_o
);

  localparam logic signed [SUM_W-1:0] CELLS_S = SUM_W'(CELLS);

  logic [3:0]                vld_q, vld_d;
  logic signed [DIFF_W-1:0]  dx_q, dx_d, dy_q, dy_d;
  logic signed [PROD_W-1:0]  prod_x, prod_y;
  logic signed [COORD_W-1:0] col_q, col_d, row_q, row_d, col2_q;
  logic signed [ROWP_W-1:0]  rowp_q, rowp_d;
  logic signed [SUM_W-1:0]   sum;
  logic [AW-1:0]             cell_q, cell_d;
  logic                      oor_q, oor_d;

  // Stage one: offset from the grid origin
  assign dx_d = DIFF_W'(pos_x_i) - DIFF_W'(cfg_i.x_origin);
  assign dy_d = DIFF_W'(pos_y_i) - DIFF_W'(cfg_i.y_origin);

  // Stage two: scale by the reciprocal step, floor drops the fraction
  assign prod_x = dx_q * $signed({1'b0, cfg_i.x_inv_step});
  assign prod_y = dy_q * $signed({1'b0, cfg_i.y_inv_step});
  assign col_d  = prod_x[FRAC_BITS+COORD_W-1:FRAC_BITS];
  assign row_d  = prod_y[FRAC_BITS+COORD_W-1:FRAC_BITS];

  // Stage three: row times column count
  assign rowp_d = row_q * $signed({1'b0, cfg_i.grid_columns});

  // Stage four: combine and force cells outside the grid to zero
  assign sum    = SUM_W'(rowp_q) + SUM_W'(col2_q);
  assign oor_d  = (sum < 0) || (sum >= CELLS_S);
  assign cell_d = oor_d ? '0 : AW'(sum);

  assign vld_d = {vld_q[2:0], start_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    col_q  <= col_d;
    row_q  <= row_d;
    rowp_q <= rowp_d;
    col2_q <= col_q;
    cell_q <= cell_d;
    oor_q  <= oor_d;
  end

  assign valid_o = vld_q[3];
  assign cell_o  = cell_q;
  assign oor_o   = oor_q;

endmodule

/* rtl/pgb_cell_mem.sv */
// Cell store: per-cell count and first particle, one read and one write port.
module pgb_cell_mem import pgb_pkg::*; #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned CNT_W = 13
) (
  input  logic              clk_i,
  input  mem_ctl_t          ctl_i,
  input  logic [AW-1:0]     rd_addr_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [CNT_W-1:0]  wr_count_i,
  input  logic [PIDX_W-1:0] wr_first_i,
  output logic [CNT_W-1:0]  rd_count_o,
  output logic [PIDX_W-1:0] rd_first_o
);

  logic [CNT_W-1:0]  count_mem [DEPTH];
  logic [PIDX_W-1:0] first_mem [DEPTH];
  logic [CNT_W-1:0]  rd_count_q;
  logic [PIDX_W-1:0] rd_first_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      count_mem[wr_addr_i] <= wr_count_i;
    end
    if (ctl_i.wr_first_en) begin
      first_mem[wr_addr_i] <= wr_first_i;
    end
  end

  // Registered read port; data holds until the next read
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_count_q <= count_mem[rd_addr_i];
      rd_first_q <= first_mem[rd_addr_i];
    end
  end

  assign rd_count_o = rd_count_q;
  assign rd_first_o = rd_first_q;

endmodule

/* rtl/particle_grid_binning.sv */
// Particle grid binning: command sequencer, configuration and result register.
// Bins 2-D Q4.12 positions into a uniform grid held in an on-chip cell store and
// reports a cell's particle count and first particle. One word is worked on at a
// time: a bin passes four address stages, one store read and one write-back, a read
// passes one store read, and a clear sweeps the count store one cell per cycle. The
// write-back and the result wait until the output register is free. After reset the
// block runs the same sweep over every cell before it accepts its first word;
// configuration writes are taken at any time. A result waits in the output register
// while the next word is accepted.
module particle_grid_binning import pgb_pkg::*; #(
  parameter int unsigned CELLS     = 1024,
  parameter int unsigned PARTICLES = 4096
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Configuration writes
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  // Command words
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [CMD_W-1:0]         command_i,
  input  logic signed [POS_W-1:0]  pos_x_i,
  input  logic signed [POS_W-1:0]  pos_y_i,
  input  logic [PIDX_W-1:0]        particle_index_i,
  input  logic [SEL_W-1:0]         cell_select_i,
  // Result words
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [CIDX_W-1:0]        cell_index_o,
  output logic [COUNT_W-1:0]       cell_count_o,
  output logic [PIDX_W-1:0]        first_index_o,
  output logic                     out_of_range_o
);

  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CNT_W = $clog2(PARTICLES + 1);
  localparam int unsigned IW    = (AW > CIDX_W) ? AW : CIDX_W;
  localparam int unsigned CW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam logic [AW-1:0]    LAST_CELL = AW'(CELLS - 1);
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(PARTICLES);

  localparam logic [2:0] ST_SWEEP = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_CALC  = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  cfg_t              cfg_q, cfg_d;
  logic [2:0]        state_q, state_d;
  logic [AW-1:0]     sweep_q, sweep_d;
  logic              clr_rep_q, clr_rep_d;
  logic [CMD_W-1:0]  cmd_q, cmd_d;
  logic [PIDX_W-1:0] pidx_q, pidx_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic              oor_q, oor_d;

  logic              accept;
  logic              out_free;
  logic              calc_valid;
  logic [AW-1:0]     calc_cell;
  logic              calc_oor;

  mem_ctl_t          mem_ctl;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [CNT_W-1:0]  wr_count;
  logic [CNT_W-1:0]  rd_count;
  logic [PIDX_W-1:0] rd_first;
  logic [CNT_W-1:0]  new_count;
  logic [PIDX_W-1:0] new_first;

  logic              out_valid_q, out_valid_d;
  logic [CIDX_W-1:0] res_cell;
  logic [COUNT_W-1:0] res_count;
  logic [PIDX_W-1:0] res_first;
  logic              res_oor;
  logic [CIDX_W-1:0] cell_index_q;
  logic [COUNT_W-1:0] cell_count_q;
  logic [PIDX_W-1:0] first_index_q;
  logic              out_of_range_q;
  logic [IW-1:0]     cell_wide;
  logic [CW-1:0]     count_wide;

  // Configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_X_ORIGIN:   cfg_d.x_origin     = $signed(cfg_data_i);
        REG_Y_ORIGIN:   cfg_d.y_origin     = $signed(cfg_data_i);
        REG_X_INV_STEP: cfg_d.x_inv_step   = cfg_data_i;
        REG_Y_INV_STEP: cfg_d.y_inv_step   = cfg_data_i;
        REG_GRID_COLS:  cfg_d.grid_columns = cfg_data_i[COLS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_origin     <= '0;
      cfg_q.y_origin     <= '0;
      cfg_q.x_inv_step   <= INV_STEP_RST;
      cfg_q.y_inv_step   <= INV_STEP_RST;
      cfg_q.grid_columns <= GRID_COLS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Cell address pipeline
  pgb_cell_calc #(
    .CELLS (CELLS),
    .AW    (AW)
  ) u_calc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && (command_i == CMD_BIN)),
    .pos_x_i (pos_x_i),
    .pos_y_i (pos_y_i),
    .cfg_i   (cfg_q),
    .valid_o (calc_valid),
    .cell_o  (calc_cell),
    .oor_o   (calc_oor)
  );

  // Cell store
  pgb_cell_mem #(
    .DEPTH (CELLS),
    .AW    (AW),
    .CNT_W (CNT_W)
  ) u_mem (
    .clk_i      (clk_i),
    .ctl_i      (mem_ctl),
    .rd_addr_i  (rd_addr),
    .wr_addr_i  (wr_addr),
    .wr_count_i (wr_count),
    .wr_first_i (new_first),
    .rd_count_o (rd_count),
    .rd_first_o (rd_first)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Update the cell: saturate the count, take the particle on an empty cell
  assign new_count = (rd_count < CNT_MAX) ? rd_count + 1'b1 : rd_count;
  assign new_first = (rd_count == '0) ? pidx_q : rd_first;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    sweep_d     = sweep_q;
    clr_rep_d   = clr_rep_q;
    cmd_d       = cmd_q;
    pidx_d      = pidx_q;
    addr_d      = addr_q;
    oor_d       = oor_q;
    mem_ctl     = '0;
    rd_addr     = addr_q;
    wr_addr     = addr_q;
    wr_count    = new_count;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_SWEEP: begin
        // Zero one count per cycle
        mem_ctl.wr_en = 1'b1;
        wr_addr       = sweep_q;
        wr_count      = '0;
        sweep_d       = sweep_q + 1'b1;
        if (sweep_q == LAST_CELL) begin
          sweep_d   = '0;
          clr_rep_d = 1'b0;
          state_d   = clr_rep_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_d  = command_i;
          pidx_d = particle_index_i;
          case (command_i)
            CMD_BIN: state_d = ST_CALC;
            CMD_READ: begin
              oor_d   = (32'(cell_select_i) >= CELLS);
              addr_d  = oor_d ? '0 : AW'(cell_select_i);
              state_d = ST_RD;
            end
            CMD_CLEAR: begin
              clr_rep_d = 1'b1;
              sweep_d   = '0;
              state_d   = ST_SWEEP;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_CALC: begin
        if (calc_valid) begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = calc_cell;
          addr_d        = calc_cell;
          oor_d         = calc_oor;
          state_d       = ST_DONE;
        end
      end
      ST_RD: begin
        mem_ctl.rd_en = 1'b1;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        // Write back and hand the result word over once the output is free
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (cmd_q == CMD_BIN) begin
            mem_ctl.wr_en       = 1'b1;
            mem_ctl.wr_first_en = (rd_count == '0);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      sweep_q     <= '0;
      clr_rep_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      clr_rep_q   <= clr_rep_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    pidx_q <= pidx_d;
    addr_q <= addr_d;
    oor_q  <= oor_d;
  end

  // Form the result word
  assign cell_wide = IW'(addr_q);
  always_comb begin
    res_cell   = '0;
    res_count  = '0;
    res_first  = '0;
    res_oor    = 1'b0;
    count_wide = '0;
    case (cmd_q)
      CMD_BIN: begin
        count_wide = CW'(new_count);
        res_cell   = cell_wide[CIDX_W-1:0];
        res_count  = count_wide[COUNT_W-1:0];
        res_first  = new_first;
        res_oor    = oor_q;
      end
      CMD_READ: begin
        count_wide = CW'(rd_count);
        res_cell   = cell_wide[CIDX_W-1:0];
        res_count  = count_wide[COUNT_W-1:0];
        res_first  = (rd_count != '0) ? rd_first : '0;
        res_oor    = oor_q;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DONE) && out_free) begin
      cell_index_q   <= res_cell;
      cell_count_q   <= res_count;
      first_index_q  <= res_first;
      out_of_range_q <= res_oor;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cell_index_o   = cell_index_q;
  assign cell_count_o   = cell_count_q;
  assign first_index_o  = first_index_q;
  assign out_of_range_o = out_of_range_q;

endmodule
